FILE: sv/eetc_pkg.sv
package eetc_pkg;

	localparam int ADC_BITS  = 10;
	localparam int FRAC_BITS = 8;
	localparam int MAX_CAL   = 512;
	localparam int ALPHA_W   = 16;
	localparam int ENV_W     = ADC_BITS + FRAC_BITS;
	localparam int THR_W     = ENV_W + 2;
	localparam int CNT_W     = $clog2(MAX_CAL) + 1;
	localparam int SUM_W     = ENV_W + CNT_W - 1;
	localparam int SQ_W      = 2 * ENV_W + CNT_W - 1;
	localparam int NUM_W     = SQ_W + CNT_W;
	localparam int DIV_W     = NUM_W;
	localparam int DVS_W     = 2 * CNT_W - 1;
	localparam int REM_W     = DVS_W + 1;
	localparam int CS_W      = REM_W + 1;
	localparam int VAR_W     = 2 * ENV_W;
	localparam int MUL_W     = SUM_W;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ENVSUM_W  = ENV_W + ALPHA_W + 1;
	localparam int ITER_W    = $clog2(DIV_W);
	localparam int IDX_W     = 2;
	localparam int CFG_W     = ALPHA_W;

	localparam logic [IDX_W-1:0] REG_ALPHA_GAIN    = 2'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_OFFSET = 2'd1;
	localparam logic [IDX_W-1:0] REG_CALIB_LEN     = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd6554;
	localparam logic [ADC_BITS-1:0] CENTER_RESET = 10'd341;
	localparam logic [CNT_W-1:0]   CALIB_RESET  = 10'd300;

	localparam logic [0:0] OP_SAMPLE = 1'b0;
	localparam logic [0:0] OP_CALIB  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_RISE,
		ST_MUL_DECAY,
		ST_ENV,
		ST_SQ,
		ST_ACC,
		ST_MEAN_DIV,
		ST_NUM_LO,
		ST_NUM_HI,
		ST_SUMSQ,
		ST_DIFF,
		ST_VAR_LOAD,
		ST_VAR_DIV,
		ST_SQRT_LOAD,
		ST_SQRT,
		ST_THR,
		ST_RESULT
	} state_t;

endpackage

FILE: sv/eetc_if.sv
interface eetc_in_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [eetc_pkg::ADC_BITS-1:0] adc_sample;

	modport source (output valid, output op, output adc_sample, input ready);
	modport sink   (input valid, input op, input adc_sample, output ready);
endinterface

interface eetc_out_if;
	logic                       valid;
	logic                       ready;
	logic [eetc_pkg::ENV_W-1:0] envelope_level;
	logic                       active;
	logic                       calib_done;
	logic [eetc_pkg::THR_W-1:0] upper_threshold;

	modport source (output valid, output envelope_level, output active, output calib_done,
		output upper_threshold, input ready);
	modport sink   (input valid, input envelope_level, input active, input calib_done,
		input upper_threshold, output ready);
endinterface

FILE: sv/emg_envelope_threshold_calibrator.sv
// Sample item: MUL_RISE, MUL_DECAY and ENV form the result (SQ and ACC follow while a
// calibration run is open); no new item is accepted until that result has been loaded.
// Item that closes a run: the shared restoring divider then runs
// 55 steps twice (mean, variance) and the square root 18 steps, one bit per cycle.
// Start-calibration item: goes straight to the result. A waiting result holds the sequencer in its last state.
// arst_n clears the envelope, sets the threshold to all ones, loads register defaults.
module emg_envelope_threshold_calibrator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [eetc_pkg::IDX_W-1:0]      cfg_index,
	input  logic [eetc_pkg::CFG_W-1:0]      cfg_wdata,
	eetc_in_if.sink                         samples,
	eetc_out_if.source                      results
);

	localparam int ENV_W    = eetc_pkg::ENV_W;
	localparam int THR_W    = eetc_pkg::THR_W;
	localparam int CNT_W    = eetc_pkg::CNT_W;
	localparam int SUM_W    = eetc_pkg::SUM_W;
	localparam int SQ_W     = eetc_pkg::SQ_W;
	localparam int NUM_W    = eetc_pkg::NUM_W;
	localparam int DIV_W    = eetc_pkg::DIV_W;
	localparam int DVS_W    = eetc_pkg::DVS_W;
	localparam int REM_W    = eetc_pkg::REM_W;
	localparam int CS_W     = eetc_pkg::CS_W;
	localparam int VAR_W    = eetc_pkg::VAR_W;
	localparam int MUL_W    = eetc_pkg::MUL_W;
	localparam int PROD_W   = eetc_pkg::PROD_W;
	localparam int ALPHA_W  = eetc_pkg::ALPHA_W;
	localparam int ADC_BITS = eetc_pkg::ADC_BITS;
	localparam int FRAC_BITS = eetc_pkg::FRAC_BITS;
	localparam int ENVSUM_W = eetc_pkg::ENVSUM_W;
	localparam int ITER_W   = eetc_pkg::ITER_W;

	localparam logic [ALPHA_W:0]    ALPHA_ONE = (ALPHA_W+1)'(1) << ALPHA_W;
	localparam logic [ENVSUM_W-1:0] ROUND_HALF = ENVSUM_W'(1) << (ALPHA_W - 1);
	localparam logic [CNT_W-1:0]    LEN_MAX = CNT_W'(eetc_pkg::MAX_CAL);
	localparam logic [ITER_W-1:0]   DIV_LAST = ITER_W'(DIV_W - 1);
	localparam logic [ITER_W-1:0]   SQRT_LAST = ITER_W'(ENV_W - 1);

	eetc_pkg::state_t state_q, state_d;

	logic [ALPHA_W-1:0]  alpha_q;
	logic [ADC_BITS-1:0] center_q;
	logic [CNT_W-1:0]    calib_len_q;

	logic [ENV_W-1:0]    env_q;
	logic [THR_W-1:0]    thr_q;
	logic [ENV_W-1:0]    mean_q;
	logic                calibrating_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sumsq_q;
	logic                done_q;

	logic [ENV_W-1:0]    rect_q;
	logic [PROD_W-1:0]   prod_q;
	logic [NUM_W-1:0]    acc_q;
	logic [DIV_W-1:0]    div_q;
	logic [DVS_W-1:0]    divisor_q;
	logic [REM_W-1:0]    rem_q;
	logic [ENV_W-1:0]    root_q;
	logic [ITER_W-1:0]   iter_q;

	logic                res_valid_q;
	logic [ENV_W-1:0]    res_env_q;
	logic                res_active_q;
	logic                res_done_q;
	logic [THR_W-1:0]    res_thr_q;

	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [CS_W-1:0]     cs_a, cs_b, cs_diff;
	logic                cs_ge;
	logic [ADC_BITS-1:0] mag;
	logic [ENVSUM_W-1:0] env_sum;
	logic [CNT_W-1:0]    run_len;
	logic                run_end;
	logic                accept;
	logic                res_load;
	logic [NUM_W-1:0]    s2_ext;
	logic [THR_W:0]      thr_sum;

	assign accept   = samples.valid && samples.ready;
	assign res_load = (state_q == eetc_pkg::ST_RESULT) && (!res_valid_q || results.ready);

	assign samples.ready           = (state_q == eetc_pkg::ST_IDLE);
	assign results.valid           = res_valid_q;
	assign results.envelope_level  = res_env_q;
	assign results.active          = res_active_q;
	assign results.calib_done      = res_done_q;
	assign results.upper_threshold = res_thr_q;

	assign mag = (samples.adc_sample >= center_q) ? samples.adc_sample - center_q
		: center_q - samples.adc_sample;

	always_comb begin
		run_len = calib_len_q;
		if (calib_len_q == '0) begin
			run_len = CNT_W'(1);
		end else if (calib_len_q > LEN_MAX) begin
			run_len = LEN_MAX;
		end
	end
	assign run_end = (count_q >= run_len);

	assign env_sum = ENVSUM_W'(acc_q) + ENVSUM_W'(prod_q) + ROUND_HALF;
	assign s2_ext  = NUM_W'(prod_q);
	assign thr_sum = (THR_W+1)'(mean_q) + (THR_W+1)'({root_q, 1'b0}) + (THR_W+1)'(root_q);

	// shared compare-subtract: divider step or square-root step
	assign cs_ge   = (cs_a >= cs_b);
	assign cs_diff = cs_a - cs_b;

	always_comb begin
		cs_a = {rem_q, div_q[DIV_W-1]};
		cs_b = CS_W'(divisor_q);
		if (state_q == eetc_pkg::ST_SQRT) begin
			cs_a = {rem_q[REM_W-2:0], div_q[DIV_W-1 -: 2]};
			cs_b = CS_W'({root_q, 2'b01});
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			eetc_pkg::ST_MUL_RISE: begin
				mul_a = MUL_W'(alpha_q);
				mul_b = MUL_W'(rect_q);
			end
			eetc_pkg::ST_MUL_DECAY: begin
				mul_a = MUL_W'(ALPHA_ONE - (ALPHA_W+1)'(alpha_q));
				mul_b = MUL_W'(env_q);
			end
			eetc_pkg::ST_SQ: begin
				mul_a = MUL_W'(env_q);
				mul_b = MUL_W'(env_q);
			end
			eetc_pkg::ST_NUM_LO: begin
				mul_a = MUL_W'(count_q);
				mul_b = sumsq_q[MUL_W-1:0];
			end
			eetc_pkg::ST_NUM_HI: begin
				mul_a = MUL_W'(count_q);
				mul_b = MUL_W'(sumsq_q[SQ_W-1:MUL_W]);
			end
			eetc_pkg::ST_SUMSQ: begin
				mul_a = MUL_W'(sum_q);
				mul_b = MUL_W'(sum_q);
			end
			eetc_pkg::ST_DIFF: begin
				mul_a = MUL_W'(count_q);
				mul_b = MUL_W'(count_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			eetc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (samples.op == eetc_pkg::OP_CALIB) ? eetc_pkg::ST_RESULT
						: eetc_pkg::ST_MUL_RISE;
				end
			end
			eetc_pkg::ST_MUL_RISE:  state_d = eetc_pkg::ST_MUL_DECAY;
			eetc_pkg::ST_MUL_DECAY: state_d = eetc_pkg::ST_ENV;
			eetc_pkg::ST_ENV: begin
				state_d = calibrating_q ? eetc_pkg::ST_SQ : eetc_pkg::ST_RESULT;
			end
			eetc_pkg::ST_SQ:        state_d = eetc_pkg::ST_ACC;
			eetc_pkg::ST_ACC: begin
				state_d = run_end ? eetc_pkg::ST_MEAN_DIV : eetc_pkg::ST_RESULT;
			end
			eetc_pkg::ST_MEAN_DIV: begin
				if (iter_q == DIV_LAST) begin
					state_d = eetc_pkg::ST_NUM_LO;
				end
			end
			eetc_pkg::ST_NUM_LO:    state_d = eetc_pkg::ST_NUM_HI;
			eetc_pkg::ST_NUM_HI:    state_d = eetc_pkg::ST_SUMSQ;
			eetc_pkg::ST_SUMSQ:     state_d = eetc_pkg::ST_DIFF;
			eetc_pkg::ST_DIFF:      state_d = eetc_pkg::ST_VAR_LOAD;
			eetc_pkg::ST_VAR_LOAD:  state_d = eetc_pkg::ST_VAR_DIV;
			eetc_pkg::ST_VAR_DIV: begin
				if (iter_q == DIV_LAST) begin
					state_d = eetc_pkg::ST_SQRT_LOAD;
				end
			end
			eetc_pkg::ST_SQRT_LOAD: state_d = eetc_pkg::ST_SQRT;
			eetc_pkg::ST_SQRT: begin
				if (iter_q == SQRT_LAST) begin
					state_d = eetc_pkg::ST_THR;
				end
			end
			eetc_pkg::ST_THR:       state_d = eetc_pkg::ST_RESULT;
			eetc_pkg::ST_RESULT: begin
				if (res_load) begin
					state_d = eetc_pkg::ST_IDLE;
				end
			end
			default:                state_d = eetc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eetc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= eetc_pkg::ALPHA_RESET;
			center_q    <= eetc_pkg::CENTER_RESET;
			calib_len_q <= eetc_pkg::CALIB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eetc_pkg::REG_ALPHA_GAIN:    alpha_q     <= cfg_wdata[ALPHA_W-1:0];
				eetc_pkg::REG_CENTER_OFFSET: center_q    <= cfg_wdata[ADC_BITS-1:0];
				eetc_pkg::REG_CALIB_LEN:     calib_len_q <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q         <= '0;
			thr_q         <= '1;
			mean_q        <= '0;
			calibrating_q <= 1'b0;
			count_q       <= '0;
			sum_q         <= '0;
			sumsq_q       <= '0;
			done_q        <= 1'b0;
		end else begin
			unique case (state_q)
				eetc_pkg::ST_IDLE: begin
					if (accept) begin
						done_q <= 1'b0;
						if (samples.op == eetc_pkg::OP_CALIB) begin
							calibrating_q <= 1'b1;
							count_q       <= '0;
							sum_q         <= '0;
							sumsq_q       <= '0;
						end
					end
				end
				eetc_pkg::ST_ENV: begin
					env_q <= env_sum[ALPHA_W +: ENV_W];
				end
				eetc_pkg::ST_SQ: begin
					sum_q   <= sum_q + SUM_W'(env_q);
					count_q <= count_q + CNT_W'(1);
				end
				eetc_pkg::ST_ACC: begin
					sumsq_q <= sumsq_q + SQ_W'(prod_q);
				end
				eetc_pkg::ST_NUM_LO: begin
					mean_q <= div_q[ENV_W-1:0];
				end
				eetc_pkg::ST_THR: begin
					thr_q         <= thr_sum[THR_W] ? '1 : thr_sum[THR_W-1:0];
					calibrating_q <= 1'b0;
					count_q       <= '0;
					done_q        <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of the shared units
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			eetc_pkg::ST_IDLE: begin
				rect_q <= {mag, {FRAC_BITS{1'b0}}};
			end
			eetc_pkg::ST_MUL_DECAY: begin
				acc_q <= NUM_W'(prod_q);
			end
			eetc_pkg::ST_ACC: begin
				div_q     <= DIV_W'(sum_q);
				divisor_q <= DVS_W'(count_q);
				rem_q     <= '0;
				iter_q    <= '0;
			end
			eetc_pkg::ST_MEAN_DIV, eetc_pkg::ST_VAR_DIV: begin
				rem_q  <= cs_ge ? cs_diff[REM_W-1:0] : cs_a[REM_W-1:0];
				div_q  <= {div_q[DIV_W-2:0], cs_ge};
				iter_q <= iter_q + ITER_W'(1);
			end
			eetc_pkg::ST_NUM_HI: begin
				acc_q <= NUM_W'(prod_q);
			end
			eetc_pkg::ST_SUMSQ: begin
				acc_q <= acc_q + {prod_q[NUM_W-MUL_W-1:0], {MUL_W{1'b0}}};
			end
			eetc_pkg::ST_DIFF: begin
				div_q <= (acc_q > s2_ext) ? acc_q - s2_ext : '0;
			end
			eetc_pkg::ST_VAR_LOAD: begin
				divisor_q <= prod_q[DVS_W-1:0];
				rem_q     <= '0;
				iter_q    <= '0;
			end
			eetc_pkg::ST_SQRT_LOAD: begin
				// variance to the top of the shifter, two bits per root step
				div_q  <= {div_q[VAR_W-1:0], {(DIV_W-VAR_W){1'b0}}};
				rem_q  <= '0;
				root_q <= '0;
				iter_q <= '0;
			end
			eetc_pkg::ST_SQRT: begin
				rem_q  <= cs_ge ? cs_diff[REM_W-1:0] : cs_a[REM_W-1:0];
				root_q <= {root_q[ENV_W-2:0], cs_ge};
				div_q  <= {div_q[DIV_W-3:0], 2'b00};
				iter_q <= iter_q + ITER_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_env_q    <= env_q;
			res_active_q <= (THR_W'(env_q) > thr_q);
			res_done_q   <= done_q;
			res_thr_q    <= thr_q;
		end
	end

endmodule
